FILE: rtl/hff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hff_pkg
// shared types, constants and helpers of the hex field formatter
// ----------------------------------------------------------------------------
package hff_pkg;

    localparam int CNT_W   = 6;   // character counts, at most 63
    localparam int Q_DEPTH = 2;   // job queue between front and back

    localparam logic [6:0] CH_SPACE   = 7'd32;
    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_X_LOWER = 7'd120;
    localparam logic [6:0] CH_X_UPPER = 7'd88;
    localparam logic [6:0] CH_A_LOWER = 7'd97;
    localparam logic [6:0] CH_A_UPPER = 7'd65;
    localparam logic [3:0] DEC_MAX    = 4'd9;

    // one formatting job, as handed from the front to the back
    typedef struct packed {
        logic [31:0]      digits;  // value shifted so the first digit sits on top
        logic             upper;
        logic [CNT_W-1:0] pre;     // leading spaces
        logic             pfx;     // prefix present
        logic [CNT_W-1:0] zeros;   // precision zeros
        logic [3:0]       dig;     // significant digits, 1 to 8
        logic [CNT_W-1:0] post;    // trailing spaces
        logic [CNT_W-1:0] total;   // characters to emit after truncation
    } hff_job_t;

    typedef struct packed {
        logic [1:0] level;
        logic       push;
        logic       pop;
    } hff_q_status_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] rem;
    } hff_bk_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE,
        BK_PFX,
        BK_ZERO,
        BK_DIG,
        BK_POST
    } hff_bk_state_t;

    // number of hex digits without leading zeros, at least one
    function automatic logic [3:0] hex_len(input logic [31:0] v);
        logic [3:0] len;
        len = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if ((v >> (4 * i)) != 32'd0)
            begin
                len = 4'(i + 1);
            end
        end
        return len;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? CH_A_UPPER : CH_A_LOWER;
        if (d > DEC_MAX)
        begin
            return base + 7'(d - 4'd10);
        end
        return CH_ZERO + 7'(d);
    endfunction

endpackage

FILE: rtl/hff_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hff_front
// input stage: takes a beat and works out the layout of its field
// ----------------------------------------------------------------------------
module hff_front #(
    parameter int MAX_FIELD_WIDTH = 56
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     in_value,
    input  logic            in_upper,
    input  logic [5:0]      in_fw,
    input  logic [5:0]      in_md,
    input  logic            in_prefix,
    input  logic            in_left,
    output logic            job_valid,
    input  logic            job_ready,
    output hff_pkg::hff_job_t job
);
    import hff_pkg::*;

    localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_FIELD_WIDTH);

    logic        stg_valid_reg, stg_valid_next;
    logic [31:0] value_reg;
    logic        upper_reg, prefix_reg, left_reg;
    logic [5:0]  fw_reg, md_reg;

    logic             push;
    logic [CNT_W-1:0] fw_sat, md_sat, digits, spaces;
    logic [3:0]       nlen;
    logic             pfx;
    logic [CNT_W:0]   body, sum;
    logic [4:0]       shamt;

    assign push     = stg_valid_reg && job_ready;
    assign in_ready = !stg_valid_reg || push;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_valid && in_ready)
        begin
            stg_valid_next = 1'b1;
        end
        else if (push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            value_reg  <= in_value;
            upper_reg  <= in_upper;
            fw_reg     <= in_fw;
            md_reg     <= in_md;
            prefix_reg <= in_prefix;
            left_reg   <= in_left;
        end
    end

    // layout of the field
    always_comb
    begin
        fw_sat = (fw_reg > MAXW) ? MAXW : fw_reg;
        md_sat = (md_reg > MAXW) ? MAXW : md_reg;
        nlen   = hex_len(value_reg);
        pfx    = prefix_reg && (value_reg != 32'd0);
        digits = (md_sat > CNT_W'(nlen)) ? md_sat : CNT_W'(nlen);
        body   = {1'b0, digits} + (pfx ? (CNT_W+1)'(2) : (CNT_W+1)'(0));
        spaces = ({1'b0, fw_sat} > body) ? CNT_W'({1'b0, fw_sat} - body) : '0;
        sum    = body + (CNT_W+1)'(spaces);
        shamt  = {3'(4'd8 - nlen), 2'b00};

        job.digits = value_reg << shamt;
        job.upper  = upper_reg;
        job.pre    = left_reg ? '0 : spaces;
        job.pfx    = pfx;
        job.zeros  = digits - CNT_W'(nlen);
        job.dig    = nlen;
        job.post   = left_reg ? spaces : '0;
        job.total  = (sum > (CNT_W+1)'(MAXW)) ? MAXW : CNT_W'(sum);
    end

    assign job_valid = stg_valid_reg;

endmodule

FILE: rtl/hff_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hff_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module hff_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  hff_pkg::hff_job_t     wr_job,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output hff_pkg::hff_job_t     rd_job,
    output hff_pkg::hff_q_status_t status
);
    import hff_pkg::*;

    hff_job_t   mem [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;
    logic       push, pop;

    assign wr_ready = (level_reg != 2'(Q_DEPTH));
    assign rd_valid = (level_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    assign status.level = level_reg;
    assign status.push  = push;
    assign status.pop   = pop;

endmodule

FILE: rtl/hff_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hff_back
// character sequencer: walks the field phases and fills the output register
// ----------------------------------------------------------------------------
module hff_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  hff_pkg::hff_job_t      job,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [6:0]             out_char,
    output logic                   out_last,
    output logic [31:0]            out_total,
    output hff_pkg::hff_bk_status_t status
);
    import hff_pkg::*;

    hff_bk_state_t    state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [31:0]      val_reg, val_next;
    logic             upper_reg, upper_next;
    logic             pfx_reg, pfx_next;
    logic [CNT_W-1:0] zeros_reg, zeros_next;
    logic [3:0]       dig_reg, dig_next;
    logic [CNT_W-1:0] post_reg, post_next;
    logic             ovalid_reg, ovalid_next;
    logic [6:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [31:0]      count_reg, count_next;

    logic       out_free, emit;
    logic [6:0] chr;

    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        val_next    = val_reg;
        upper_next  = upper_reg;
        pfx_next    = pfx_reg;
        zeros_next  = zeros_reg;
        dig_next    = dig_reg;
        post_next   = post_reg;
        job_ready   = 1'b0;
        emit        = 1'b0;
        chr         = CH_SPACE;

        unique case (state_reg)
            BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    val_next   = job.digits;
                    upper_next = job.upper;
                    pfx_next   = job.pfx;
                    zeros_next = job.zeros;
                    dig_next   = job.dig;
                    post_next  = job.post;
                    rem_next   = job.total;
                    priority if (job.pre != '0)
                    begin
                        state_next = BK_PRE;
                        cnt_next   = job.pre;
                    end
                    else if (job.pfx)
                    begin
                        state_next = BK_PFX;
                        cnt_next   = CNT_W'(2);
                    end
                    else if (job.zeros != '0)
                    begin
                        state_next = BK_ZERO;
                        cnt_next   = job.zeros;
                    end
                    else
                    begin
                        state_next = BK_DIG;
                        cnt_next   = CNT_W'(job.dig);
                    end
                end
            end
            default:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                    rem_next = rem_reg - CNT_W'(1);
                    unique case (state_reg)
                        BK_PFX:  chr = (cnt_reg == CNT_W'(2)) ? CH_ZERO :
                                       (upper_reg ? CH_X_UPPER : CH_X_LOWER);
                        BK_ZERO: chr = CH_ZERO;
                        BK_DIG:
                        begin
                            chr      = hex_char(val_reg[31:28], upper_reg);
                            val_next = val_reg << 4;
                        end
                        default: chr = CH_SPACE;
                    endcase

                    // end at the last char, else leave a spent phase, skip empties
                    priority if (rem_reg == CNT_W'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (cnt_reg == CNT_W'(1))
                    begin
                        priority if (state_reg == BK_PRE && pfx_reg)
                        begin
                            state_next = BK_PFX;
                            cnt_next   = CNT_W'(2);
                        end
                        else if ((state_reg == BK_PRE || state_reg == BK_PFX)
                                 && zeros_reg != '0)
                        begin
                            state_next = BK_ZERO;
                            cnt_next   = zeros_reg;
                        end
                        else if (state_reg == BK_PRE || state_reg == BK_PFX
                                 || state_reg == BK_ZERO)
                        begin
                            state_next = BK_DIG;
                            cnt_next   = CNT_W'(dig_reg);
                        end
                        else if (state_reg == BK_DIG && post_reg != '0)
                        begin
                            state_next = BK_POST;
                            cnt_next   = post_reg;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            char_next   = chr;
            last_next   = (rem_reg == CNT_W'(1));
            count_next  = count_reg + 32'd1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
            count_reg  <= 32'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        upper_reg <= upper_next;
        pfx_reg   <= pfx_next;
        zeros_reg <= zeros_next;
        dig_reg   <= dig_next;
        post_reg  <= post_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_char    = char_reg;
    assign out_last    = last_reg;
    assign out_total   = count_reg;
    assign status.busy = (state_reg != BK_IDLE);
    assign status.rem  = rem_reg;

endmodule

FILE: rtl/hex_field_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_field_formatter_core
// printf style hex field formatter, one ascii character per output beat
// ----------------------------------------------------------------------------
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | value, upper_case, field_width, min_digits,
//            |           | with_prefix, left_align (one field per beat)
//  m_axis    | out       | character, total_printed; tlast on final char
//
//  the back sequencer loads an item of n characters (1 to MAX_FIELD_WIDTH)
//  in idle, then sends one character per cycle while m_axis is not stalled
//  rst_n clears the handshake state, the queue and the running count
//  the front stage and the 2-entry job queue keep taking beats while the
//  sequencer works; a stalled m_axis holds the sequencer, and the input
//  side stalls only once the queue and the front stage are full
//
module hex_field_formatter_core #(
    parameter int MAX_FIELD_WIDTH = 56
) (
    input  logic        clk,
    input  logic        rst_n,
    // value[31:0], upper_case[32], field_width[38:33], min_digits[44:39],
    // with_prefix[45], left_align[46], zero[47]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // character[6:0], total_printed[38:7], zero[39]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import hff_pkg::*;

    // front to queue
    logic           fr_valid, fr_ready;
    hff_job_t       fr_job;
    // queue to back
    logic           q_valid, q_ready;
    hff_job_t       q_job;
    hff_q_status_t  q_status;
    hff_bk_status_t bk_status;

    logic [6:0]  out_char;
    logic [31:0] out_total;

    // classify the beat and work out pad and digit counts
    hff_front #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_value  (s_axis_tdata[31:0]),
        .in_upper  (s_axis_tdata[32]),
        .in_fw     (s_axis_tdata[38:33]),
        .in_md     (s_axis_tdata[44:39]),
        .in_prefix (s_axis_tdata[45]),
        .in_left   (s_axis_tdata[46]),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    // decouples the front from the sequencer
    hff_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_job   (fr_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job),
        .status   (q_status)
    );

    // emits the field characters and keeps the running count
    hff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_total (out_total),
        .status    (bk_status)
    );

    assign m_axis_tdata = {1'b0, out_total, out_char};

`ifndef SYNTH
    // queue never holds more jobs than it has entries
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= 2'(Q_DEPTH))
    else $error("job queue overfilled");

    // a job taken from the queue starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.pop |=> bk_status.busy)
    else $error("sequencer did not start on a popped job");

    // the sequencer only runs with characters left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.busy |-> bk_status.rem != '0)
    else $error("sequencer busy with no characters left");

    // the sequencer pops only when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.pop |-> !bk_status.busy)
    else $error("job popped while sequencer busy");
`endif

endmodule
